// ===== hdl/hbs_pkg.sv =====
// hbs_pkg: shared types, widths, codes and helpers for the heightfield sampler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int SCALE_W   = 31;
  localparam int EDGE_W    = 9;
  localparam int EDGE_MAX  = 256;
  localparam int GRID_W    = $clog2(EDGE_MAX);
  localparam int ADDR_W    = 16;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int CFG_IDX_W = 3;

  // divider widths: signed difference, magnitude quotient, pipeline latency
  localparam int DIFF_W  = COORD_W + 1;
  localparam int QUO_W   = DIFF_W + FRAC_BITS;
  localparam int IX_W    = QUO_W - FRAC_BITS;
  localparam int DIV_LAT = QUO_W + 2;
  localparam int FRAC_W  = FRAC_BITS + 1;

  // blend datapath widths
  localparam int M_W  = DIFF_W + FRAC_W;
  localparam int A_W  = COORD_W + 3;
  localparam int DD_W = A_W + 1;
  localparam int M2_W = DD_W + FRAC_W;
  localparam int P_W  = 64;

  localparam logic [1:0] OP_HEIGHT = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_INDEX  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE     = 3'd6;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [ADDR_W-1:0]         vertex_index;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] height_out;
    logic [ADDR_W-1:0]         index_out;
    logic                      in_range;
  } rsp_t;

  // control that travels alongside the corner heights into the blend
  typedef struct packed {
    logic [1:0]               op;
    logic                     ok;
    logic [ADDR_W-1:0]        index;
    logic signed [FRAC_W-1:0] fx;
    logic signed [FRAC_W-1:0] fz;
  } tag_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] hi;
    logic signed [P_W-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/hbs_divider.sv =====
// hbs_divider: pipelined restoring divider, one quotient bit per stage
// computes |diff| * 2^FRAC_BITS / divisor with the sign kept aside; uses hbs_pkg
`timescale 1ns / 1ps

module hbs_divider (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [hbs_pkg::DIFF_W-1:0]   diff,
  input  logic [hbs_pkg::SCALE_W-1:0]         divisor,
  output logic [hbs_pkg::QUO_W-1:0]           quo,
  output logic                                neg
);

  logic signed [hbs_pkg::DIFF_W-1:0] diff_r;
  logic [hbs_pkg::DIFF_W-1:0]        mag;
  logic [hbs_pkg::SCALE_W-1:0]       dvs [0:hbs_pkg::QUO_W];
  logic [hbs_pkg::SCALE_W-1:0]       rem [1:hbs_pkg::QUO_W];
  logic [hbs_pkg::QUO_W-1:0]         w   [1:hbs_pkg::QUO_W+1];
  logic                              sgn [1:hbs_pkg::QUO_W+1];

  assign mag = diff_r[hbs_pkg::DIFF_W-1] ? hbs_pkg::DIFF_W'(-diff_r)
                                          : hbs_pkg::DIFF_W'(diff_r);

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff;
      dvs[0] <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn[1] <= diff_r[hbs_pkg::DIFF_W-1];
      w[1]   <= {mag, {hbs_pkg::FRAC_BITS{1'b0}}};
      rem[1] <= '0;
      dvs[1] <= dvs[0];
    end
  end

  for (genvar k = 1; k <= hbs_pkg::QUO_W; k++) begin : g_step
    logic [hbs_pkg::SCALE_W:0] trial;
    logic [hbs_pkg::SCALE_W:0] dif;
    logic                      ge;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem[k], w[k][hbs_pkg::QUO_W-1]};
    assign ge    = trial >= {1'b0, dvs[k]};
    assign dif   = trial - {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        w[k+1]   <= {w[k][hbs_pkg::QUO_W-2:0], ge};
        sgn[k+1] <= sgn[k];
      end
    end

    if (k < hbs_pkg::QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? dif[hbs_pkg::SCALE_W-1:0] : trial[hbs_pkg::SCALE_W-1:0];
          dvs[k+1] <= dvs[k];
        end
      end
    end
  end

  assign quo = w[hbs_pkg::QUO_W+1];
  assign neg = sgn[hbs_pkg::QUO_W+1];

endmodule

// ===== hdl/hbs_height_ram.sv =====
// hbs_height_ram: height store, one write port and two registered read ports
// depth and address width from hbs_pkg
`timescale 1ns / 1ps

module hbs_height_ram (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [hbs_pkg::ADDR_W-1:0]   waddr,
  input  logic [hbs_pkg::COORD_W-1:0]  wdata,
  input  logic [hbs_pkg::ADDR_W-1:0]   raddr_a,
  input  logic [hbs_pkg::ADDR_W-1:0]   raddr_b,
  output logic [hbs_pkg::COORD_W-1:0]  rdata_a,
  output logic [hbs_pkg::COORD_W-1:0]  rdata_b
);

  logic [hbs_pkg::COORD_W-1:0] mem [0:hbs_pkg::DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/hbs_blend.sv =====
// hbs_blend: bilinear blend of four corner heights and mapping back to world units
// eight register stages ending in the output register; uses hbs_pkg
`timescale 1ns / 1ps

module hbs_blend (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  hbs_pkg::tag_t                        tag,
  input  logic signed [hbs_pkg::COORD_W-1:0]   lo0,
  input  logic signed [hbs_pkg::COORD_W-1:0]   hi0,
  input  logic signed [hbs_pkg::COORD_W-1:0]   lo1,
  input  logic signed [hbs_pkg::COORD_W-1:0]   hi1,
  input  logic [hbs_pkg::SCALE_W-1:0]          scale_y,
  input  logic signed [hbs_pkg::COORD_W-1:0]   offset_y,
  output logic                                 out_valid,
  output hbs_pkg::rsp_t                        rsp
);

  logic          vld [1:8];
  hbs_pkg::tag_t tg  [1:7];

  logic signed [hbs_pkg::COORD_W-1:0] lo0_1, lo1_1, lo0_2, lo1_2;
  logic signed [hbs_pkg::DIFF_W-1:0]  d0, d1;
  logic signed [hbs_pkg::M_W-1:0]     m0, m1;
  logic signed [hbs_pkg::A_W-1:0]     a0, a1, a0_4, a0_5;
  logic signed [hbs_pkg::DD_W-1:0]    dd;
  logic signed [hbs_pkg::M2_W-1:0]    m2;
  logic signed [hbs_pkg::COORD_W-1:0] g;
  logic signed [hbs_pkg::P_W-1:0]     p;
  logic [hbs_pkg::SCALE_W-1:0]        s;
  logic signed [hbs_pkg::COORD_W-1:0] h;

  assign s = (scale_y == '0) ? hbs_pkg::SCALE_W'(1) : scale_y;
  assign h = hbs_pkg::sat32((p >>> hbs_pkg::FRAC_BITS) + hbs_pkg::P_W'(offset_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 8; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int i = 2; i <= 8; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[1] <= tag;
      for (int i = 2; i <= 7; i++) begin
        tg[i] <= tg[i-1];
      end
      // blend along z
      d0    <= hbs_pkg::DIFF_W'(hi0) - hbs_pkg::DIFF_W'(lo0);
      d1    <= hbs_pkg::DIFF_W'(hi1) - hbs_pkg::DIFF_W'(lo1);
      lo0_1 <= lo0;
      lo1_1 <= lo1;
      m0    <= hbs_pkg::M_W'(d0) * hbs_pkg::M_W'($signed(tg[1].fz));
      m1    <= hbs_pkg::M_W'(d1) * hbs_pkg::M_W'($signed(tg[1].fz));
      lo0_2 <= lo0_1;
      lo1_2 <= lo1_1;
      // arithmetic shift is the floor of the scaled product
      a0    <= hbs_pkg::A_W'(lo0_2) + hbs_pkg::A_W'(m0 >>> hbs_pkg::FRAC_BITS);
      a1    <= hbs_pkg::A_W'(lo1_2) + hbs_pkg::A_W'(m1 >>> hbs_pkg::FRAC_BITS);
      // blend along x
      dd    <= hbs_pkg::DD_W'(a1) - hbs_pkg::DD_W'(a0);
      a0_4  <= a0;
      m2    <= hbs_pkg::M2_W'(dd) * hbs_pkg::M2_W'($signed(tg[4].fx));
      a0_5  <= a0_4;
      g     <= hbs_pkg::sat32(hbs_pkg::P_W'(a0_5)
                              + hbs_pkg::P_W'(m2 >>> hbs_pkg::FRAC_BITS));
      p     <= hbs_pkg::P_W'(g) * $signed({{(hbs_pkg::P_W-hbs_pkg::SCALE_W){1'b0}}, s});
      rsp.height_out <= (tg[7].op == hbs_pkg::OP_HEIGHT && tg[7].ok) ? h : '0;
      rsp.index_out  <= tg[7].index;
      rsp.in_range   <= tg[7].ok;
    end
  end

  assign out_valid = vld[8];

endmodule

// ===== hdl/heightfield_bilinear_sampler.sv =====
// heightfield_bilinear_sampler: top level, config registers, grid mapping, store access
// depends on hbs_pkg, hbs_divider, hbs_height_ram, hbs_blend
`timescale 1ns / 1ps
//
// channel  | signals                                   | direction
// req      | req_valid, req_ready, req (req_t)         | in
// rsp      | rsp_valid, rsp_ready, rsp (rsp_t)         | out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// one word accepted per cycle while the pipeline advances; req_ready is low while the output stalls
// most of the pipeline is the two 51-stage divide pipelines mapping x and z to grid space
// the whole pipeline advances when the output register is empty or being taken
// rst clears valid bits and sets config registers to their defaults; the height store is not cleared
// cfg_ready is always high

module heightfield_bilinear_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  hbs_pkg::req_t                       req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output hbs_pkg::rsp_t                       rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbs_pkg::COORD_W-1:0]         cfg_data
);

  typedef struct packed {
    logic [1:0]                 op;
    logic [hbs_pkg::ADDR_W-1:0] vi;
  } side_t;

  logic signed [hbs_pkg::COORD_W-1:0] offset_x, offset_y, offset_z;
  logic [hbs_pkg::SCALE_W-1:0]        scale_x, scale_y, scale_z;
  logic [hbs_pkg::EDGE_W-1:0]         edge_vertices;
  logic [hbs_pkg::EDGE_W-1:0]         edge_eff;

  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      offset_z      <= '0;
      scale_x       <= hbs_pkg::SCALE_W'(65536);
      scale_y       <= hbs_pkg::SCALE_W'(65536);
      scale_z       <= hbs_pkg::SCALE_W'(65536);
      edge_vertices <= hbs_pkg::EDGE_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hbs_pkg::REG_OFFSET_X: offset_x      <= cfg_data;
        hbs_pkg::REG_OFFSET_Y: offset_y      <= cfg_data;
        hbs_pkg::REG_OFFSET_Z: offset_z      <= cfg_data;
        hbs_pkg::REG_SCALE_X:  scale_x       <= cfg_data[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::REG_SCALE_Y:  scale_y       <= cfg_data[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::REG_SCALE_Z:  scale_z       <= cfg_data[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::REG_EDGE:     edge_vertices <= cfg_data[hbs_pkg::EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign edge_eff  = (edge_vertices > hbs_pkg::EDGE_W'(hbs_pkg::EDGE_MAX))
                     ? hbs_pkg::EDGE_W'(hbs_pkg::EDGE_MAX) : edge_vertices;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // x lane also carries the height of a write word
  logic signed [hbs_pkg::DIFF_W-1:0] diff_x, diff_z;
  logic [hbs_pkg::SCALE_W-1:0]       dvs_x, dvs_z;
  logic                              is_wr;

  assign is_wr  = req.operation == hbs_pkg::OP_WRITE;
  assign diff_x = is_wr ? hbs_pkg::DIFF_W'(req.coord_y) - hbs_pkg::DIFF_W'(offset_y)
                        : hbs_pkg::DIFF_W'(req.coord_x) - hbs_pkg::DIFF_W'(offset_x);
  assign diff_z = hbs_pkg::DIFF_W'(req.coord_z) - hbs_pkg::DIFF_W'(offset_z);

  always_comb begin
    dvs_x = is_wr ? scale_y : scale_x;
    if (dvs_x == '0) begin
      dvs_x = hbs_pkg::SCALE_W'(1);
    end
    dvs_z = (scale_z == '0) ? hbs_pkg::SCALE_W'(1) : scale_z;
  end

  logic [hbs_pkg::QUO_W-1:0] quo_x, quo_z;
  logic                      neg_x, neg_z;

  hbs_divider u_div_x (
    .clk     (clk),
    .en      (en),
    .diff    (diff_x),
    .divisor (dvs_x),
    .quo     (quo_x),
    .neg     (neg_x)
  );

  hbs_divider u_div_z (
    .clk     (clk),
    .en      (en),
    .diff    (diff_z),
    .divisor (dvs_z),
    .quo     (quo_z),
    .neg     (neg_z)
  );

  logic  sd_vld [0:hbs_pkg::DIV_LAT-1];
  side_t sd     [0:hbs_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hbs_pkg::DIV_LAT; i++) begin
        sd_vld[i] <= 1'b0;
      end
    end else if (en) begin
      sd_vld[0] <= req_valid;
      for (int i = 1; i < hbs_pkg::DIV_LAT; i++) begin
        sd_vld[i] <= sd_vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{op: req.operation, vi: req.vertex_index};
      for (int i = 1; i < hbs_pkg::DIV_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // grid position: integer part and signed fraction of each quotient
  logic [hbs_pkg::IX_W-1:0]          ix, iz;
  logic [hbs_pkg::FRAC_BITS-1:0]     fmx, fmz;
  logic                              nn_x, nn_z;
  logic                              ok_h, ok_i, ok_w;
  logic [2*hbs_pkg::EDGE_W-1:0]      base;
  logic signed [hbs_pkg::FRAC_W-1:0] fx, fz;
  logic signed [hbs_pkg::COORD_W-1:0] wval;
  side_t                             sl;

  assign sl   = sd[hbs_pkg::DIV_LAT-1];
  assign ix   = quo_x[hbs_pkg::QUO_W-1:hbs_pkg::FRAC_BITS];
  assign iz   = quo_z[hbs_pkg::QUO_W-1:hbs_pkg::FRAC_BITS];
  assign fmx  = quo_x[hbs_pkg::FRAC_BITS-1:0];
  assign fmz  = quo_z[hbs_pkg::FRAC_BITS-1:0];
  // a small negative position still has integer part zero
  assign nn_x = !neg_x || (ix == '0);
  assign nn_z = !neg_z || (iz == '0);
  assign ok_h = nn_x && nn_z
             && ({1'b0, ix} + 1'b1 < (hbs_pkg::IX_W+1)'(edge_eff))
             && ({1'b0, iz} + 1'b1 < (hbs_pkg::IX_W+1)'(edge_eff));
  assign ok_i = nn_x && nn_z
             && (ix < hbs_pkg::IX_W'(edge_eff)) && (iz < hbs_pkg::IX_W'(edge_eff));
  assign ok_w = (2*hbs_pkg::EDGE_W)'(sl.vi)
              < (2*hbs_pkg::EDGE_W)'(edge_eff) * (2*hbs_pkg::EDGE_W)'(edge_eff);
  assign base = (2*hbs_pkg::EDGE_W)'(ix[hbs_pkg::GRID_W-1:0])
              * (2*hbs_pkg::EDGE_W)'(edge_eff)
              + (2*hbs_pkg::EDGE_W)'(iz[hbs_pkg::GRID_W-1:0]);
  assign fx   = neg_x ? -$signed({1'b0, fmx}) : $signed({1'b0, fmx});
  assign fz   = neg_z ? -$signed({1'b0, fmz}) : $signed({1'b0, fmz});
  assign wval = hbs_pkg::sat32(neg_x ? -$signed(hbs_pkg::P_W'(quo_x))
                                     : $signed(hbs_pkg::P_W'(quo_x)));

  logic                               p1_vld;
  logic [1:0]                         p1_op;
  logic [hbs_pkg::ADDR_W-1:0]         p1_vi;
  logic                               p1_okh, p1_oki, p1_okw;
  logic [hbs_pkg::ADDR_W-1:0]         p1_b;
  logic signed [hbs_pkg::FRAC_W-1:0]  p1_fx, p1_fz;
  logic signed [hbs_pkg::COORD_W-1:0] p1_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= sd_vld[hbs_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_op    <= sl.op;
      p1_vi    <= sl.vi;
      p1_okh   <= ok_h;
      p1_oki   <= ok_i;
      p1_okw   <= ok_w;
      p1_b     <= base[hbs_pkg::ADDR_W-1:0];
      p1_fx    <= fx;
      p1_fz    <= fz;
      p1_wdata <= wval;
    end
  end

  // store access: writes and corner reads share this stage, so item order holds
  logic                       p1_ok;
  logic [hbs_pkg::ADDR_W-1:0] a00, a01, a10, a11;
  logic                       ram_we;

  always_comb begin
    case (p1_op)
      hbs_pkg::OP_HEIGHT: p1_ok = p1_okh;
      hbs_pkg::OP_WRITE:  p1_ok = p1_okw;
      hbs_pkg::OP_INDEX:  p1_ok = p1_oki;
      default:            p1_ok = 1'b0;
    endcase
  end

  assign a00    = p1_b;
  assign a01    = p1_b + 1'b1;
  assign a10    = p1_b + hbs_pkg::ADDR_W'(edge_eff);
  assign a11    = p1_b + hbs_pkg::ADDR_W'(edge_eff) + 1'b1;
  assign ram_we = en && p1_vld && (p1_op == hbs_pkg::OP_WRITE) && p1_okw;

  logic [hbs_pkg::COORD_W-1:0] rd00, rd01, rd10, rd11;

  hbs_height_ram u_ram_lo (
    .clk     (clk),
    .en      (en),
    .we      (ram_we),
    .waddr   (p1_vi),
    .wdata   (p1_wdata),
    .raddr_a (a00),
    .raddr_b (a01),
    .rdata_a (rd00),
    .rdata_b (rd01)
  );

  hbs_height_ram u_ram_hi (
    .clk     (clk),
    .en      (en),
    .we      (ram_we),
    .waddr   (p1_vi),
    .wdata   (p1_wdata),
    .raddr_a (a10),
    .raddr_b (a11),
    .rdata_a (rd10),
    .rdata_b (rd11)
  );

  logic          p2_vld;
  hbs_pkg::tag_t p2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (en) begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_tag.op    <= p1_op;
      p2_tag.ok    <= p1_ok;
      p2_tag.index <= (p1_op == hbs_pkg::OP_INDEX && p1_oki) ? p1_b : '0;
      p2_tag.fx    <= p1_fx;
      p2_tag.fz    <= p1_fz;
    end
  end

  hbs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_vld),
    .tag       (p2_tag),
    .lo0       ($signed(rd00)),
    .hi0       ($signed(rd01)),
    .lo1       ($signed(rd10)),
    .hi1       ($signed(rd11)),
    .scale_y   (scale_y),
    .offset_y  (offset_y),
    .out_valid (rsp_valid),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.in_range |-> rsp.height_out == '0 && rsp.index_out == '0)
    else $error("out of range word carries nonzero fields");

  a_index_no_height: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.index_out != '0 |-> rsp.height_out == '0)
    else $error("index word carries a height");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled without output back pressure");
`endif

endmodule
